@@ sv/rbpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbpd_pkg
// Shared types, widths and tables for the Raptor block parameter derivation.
// ----------------------------------------------------------------------------
package rbpd_pkg;

	localparam int K_W    = 14;  // source block size
	localparam int X_W    = 8;
	localparam int S_W    = 9;
	localparam int H_W    = 5;
	localparam int L_W    = 14;  // output width of L and L'
	localparam int N_W    = 15;  // internal width of L and of prime candidates
	localparam int D_W    = 8;   // trial divisor
	localparam int DSQ_W  = 16;  // trial divisor squared
	localparam int CB_W   = 17;  // saturated central binomial
	localparam int Q_W    = 8;   // ceil(K/100)
	localparam int CEIL_DIVISOR = 100;

	localparam int DEFAULT_MAX_SOURCE_SYMBOLS = 8192;

	// remainder unit: one dividend bit per step
	localparam int REM_STEPS = N_W;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_X_SEARCH,
		ST_CEIL,
		ST_PRIME_CHECK,
		ST_PRIME_WAIT,
		ST_H_SEARCH,
		ST_RESULT
	} rbpd_state_t;

	typedef struct packed {
		logic           start;
		logic [N_W-1:0] dividend;
		logic [D_W-1:0] divisor;
	} rbpd_rem_req_t;

	typedef struct packed {
		logic busy;
		logic done;  // one-cycle pulse, zero valid with it
		logic zero;
	} rbpd_rem_rsp_t;

	// binomial(h, ceil(h/2)); saturates once past the field range
	function automatic logic [CB_W-1:0] central_binom(input logic [H_W-1:0] h);
		logic [CB_W-1:0] r;
		unique case (h)
			5'd0:    r = 17'd1;
			5'd1:    r = 17'd1;
			5'd2:    r = 17'd2;
			5'd3:    r = 17'd3;
			5'd4:    r = 17'd6;
			5'd5:    r = 17'd10;
			5'd6:    r = 17'd20;
			5'd7:    r = 17'd35;
			5'd8:    r = 17'd70;
			5'd9:    r = 17'd126;
			5'd10:   r = 17'd252;
			5'd11:   r = 17'd462;
			5'd12:   r = 17'd924;
			5'd13:   r = 17'd1716;
			5'd14:   r = 17'd3432;
			5'd15:   r = 17'd6435;
			5'd16:   r = 17'd12870;
			5'd17:   r = 17'd24310;
			5'd18:   r = 17'd48620;
			5'd19:   r = 17'd92378;
			default: r = '1;
		endcase
		return r;
	endfunction

endpackage

@@ sv/rbpd_rem.sv @@
// ----------------------------------------------------------------------------
// rbpd_rem
// Bit-serial restoring remainder unit: tells whether dividend mod divisor
// is zero, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rbpd_rem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbpd_pkg::rbpd_rem_req_t req,
	output rbpd_pkg::rbpd_rem_rsp_t rsp
);
	import rbpd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic [N_W-1:0]       dvd_q;
	logic [D_W-1:0]       dsr_q;
	logic [D_W-1:0]       rem_q;
	logic [D_W:0]         trial;
	logic [D_W:0]         diff;
	logic                 fits;

	assign trial = {rem_q, dvd_q[N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= REM_CNT_W'(REM_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[N_W-2:0], 1'b0};
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == '0);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("remainder unit started while busy");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("remainder done while still busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !req.start) |=> done_q)
		else $error("remainder final step did not signal done");

endmodule

@@ sv/raptor_block_parameter_derivation_top.sv @@
// ----------------------------------------------------------------------------
// raptor_block_parameter_derivation_top
// Derives the Raptor code parameters X, S, H, L and L' from a block size K.
// ----------------------------------------------------------------------------
// One word in, one word out; the block takes one word at a time and is ready
// again as soon as its result sits in the output register. The derivation
// runs the X search, the ceiling of K/100, the prime search for S, the H table
// search and the prime search for L'; the two prime searches dominate: each
// trial divisor goes through the shared bit-serial remainder unit, and a
// candidate n needs up to sqrt(n) divisors.
// K above MAX_SOURCE_SYMBOLS is saturated to it.
module raptor_block_parameter_derivation_top #(
	parameter int MAX_SOURCE_SYMBOLS = rbpd_pkg::DEFAULT_MAX_SOURCE_SYMBOLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rbpd_pkg::K_W-1:0] source_symbols,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rbpd_pkg::X_W-1:0] x_value,
	output logic [rbpd_pkg::S_W-1:0] ldpc_symbols,
	output logic [rbpd_pkg::H_W-1:0] half_symbols,
	output logic [rbpd_pkg::L_W-1:0] intermediate_symbols,
	output logic [rbpd_pkg::L_W-1:0] prime_intermediate
);
	import rbpd_pkg::*;

	localparam logic [K_W+2:0] MAX_K = (K_W+3)'(MAX_SOURCE_SYMBOLS);

	rbpd_state_t   state_q, state_d;
	rbpd_rem_req_t rem_req;
	rbpd_rem_rsp_t rem_rsp;

	logic [K_W-1:0]   k_sat;
	logic [K_W-1:0]   k_q;
	logic [K_W:0]     twok_q;
	logic [X_W-1:0]   x_q;
	logic [DSQ_W-1:0] prod_q;
	logic [K_W-1:0]   r_q;
	logic [Q_W-1:0]   q_q;
	logic [N_W-1:0]   n_q;
	logic [D_W-1:0]   d_q;
	logic [DSQ_W-1:0] dsq_q;
	logic             lp_phase_q;  // 0: searching S, 1: searching L'
	logic [S_W-1:0]   s_q;
	logic [N_W-1:0]   need_q;
	logic [H_W-1:0]   h_q;
	logic [N_W-1:0]   l_q;
	logic             out_valid_q;
	logic             load_out;

	logic [X_W-1:0] x_out_q;
	logic [S_W-1:0] s_out_q;
	logic [H_W-1:0] h_out_q;
	logic [L_W-1:0] l_out_q;
	logic [L_W-1:0] lp_out_q;

	assign k_sat = ({3'b000, source_symbols} > MAX_K) ? MAX_K[K_W-1:0] : source_symbols;

	rbpd_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		rem_req.start    = 1'b0;
		rem_req.dividend = n_q;
		rem_req.divisor  = d_q;
		load_out         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_X_SEARCH;
			end
			ST_X_SEARCH: begin
				if ({1'b0, prod_q} >= {2'b00, twok_q}) state_d = ST_CEIL;
			end
			ST_CEIL: begin
				if (r_q == '0) state_d = ST_PRIME_CHECK;
			end
			ST_PRIME_CHECK: begin
				if (n_q < N_W'(2)) begin
					state_d = ST_PRIME_CHECK;
				end else if (dsq_q > {1'b0, n_q}) begin
					state_d = lp_phase_q ? ST_RESULT : ST_H_SEARCH;
				end else begin
					rem_req.start = 1'b1;
					state_d       = ST_PRIME_WAIT;
				end
			end
			ST_PRIME_WAIT: begin
				if (rem_rsp.done) state_d = ST_PRIME_CHECK;
			end
			ST_H_SEARCH: begin
				if (central_binom(h_q) >= {2'b00, need_q}) state_d = ST_PRIME_CHECK;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath, stepped by the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					k_q        <= k_sat;
					twok_q     <= {k_sat, 1'b0};
					x_q        <= X_W'(1);
					prod_q     <= '0;
					r_q        <= k_sat;
					q_q        <= '0;
					lp_phase_q <= 1'b0;
				end
			end
			ST_X_SEARCH: begin
				// (x+1)*x = x*(x-1) + 2x
				if ({1'b0, prod_q} < {2'b00, twok_q}) begin
					prod_q <= prod_q + DSQ_W'({x_q, 1'b0});
					x_q    <= x_q + 1'b1;
				end
			end
			ST_CEIL: begin
				if (r_q != '0) begin
					r_q <= (r_q > K_W'(CEIL_DIVISOR)) ? r_q - K_W'(CEIL_DIVISOR) : '0;
					q_q <= q_q + 1'b1;
				end else begin
					n_q   <= N_W'(q_q) + N_W'(x_q);
					d_q   <= D_W'(2);
					dsq_q <= DSQ_W'(4);
				end
			end
			ST_PRIME_CHECK: begin
				if (n_q < N_W'(2)) begin
					n_q <= n_q + 1'b1;
				end else if (dsq_q > {1'b0, n_q}) begin
					if (!lp_phase_q) begin
						s_q    <= n_q[S_W-1:0];
						need_q <= N_W'(k_q) + n_q;
						h_q    <= '0;
					end
				end
			end
			ST_PRIME_WAIT: begin
				if (rem_rsp.done) begin
					if (rem_rsp.zero) begin
						n_q   <= n_q + 1'b1;
						d_q   <= D_W'(2);
						dsq_q <= DSQ_W'(4);
					end else begin
						dsq_q <= dsq_q + DSQ_W'({d_q, 1'b1});
						d_q   <= d_q + 1'b1;
					end
				end
			end
			ST_H_SEARCH: begin
				if (central_binom(h_q) < {2'b00, need_q}) begin
					h_q <= h_q + 1'b1;
				end else begin
					l_q        <= need_q + N_W'(h_q);
					n_q        <= need_q + N_W'(h_q);
					d_q        <= D_W'(2);
					dsq_q      <= DSQ_W'(4);
					lp_phase_q <= 1'b1;
				end
			end
			ST_RESULT: begin
				if (load_out) begin
					x_out_q  <= x_q;
					s_out_q  <= s_q;
					h_out_q  <= h_q;
					l_out_q  <= l_q[L_W-1:0];
					lp_out_q <= n_q[L_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready             = (state_q == ST_IDLE);
	assign out_valid            = out_valid_q;
	assign x_value              = x_out_q;
	assign ldpc_symbols         = s_out_q;
	assign half_symbols         = h_out_q;
	assign intermediate_symbols = l_out_q;
	assign prime_intermediate   = lp_out_q;

	a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rem_rsp.busy)
		else $error("remainder unit busy while idle");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result word raised outside result state");

	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME_WAIT) |-> (d_q >= D_W'(2)))
		else $error("trial divisor below two");

	a_x_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X_SEARCH && state_d == ST_CEIL)
		|-> ({1'b0, prod_q} >= {2'b00, twok_q}))
		else $error("X search left early");

endmodule

@@ dv/raptor_block_parameter_derivation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raptor_block_parameter_derivation testbench
// Sends block sizes K through the valid/ready input and checks every derived
// parameter word (X, S, H, L, L') against an integer search predictor.
// ----------------------------------------------------------------------------
module testbench;

	import rbpd_pkg::*;

	localparam int N_RANDOM    = 121;
	localparam int QUIET_WORDS = 20;     // no idling on either side at the end
	localparam int HOLD_AFTER  = 40;     // receiver holds off after this many words
	localparam int LONG_HOLD   = 12000;
	localparam int DRAIN       = 50;
	localparam int SLOW_ITEM   = 16384;  // generous bound on one derivation plus gaps

	localparam int N_DIRECTED = 19;
	localparam int DIRECTED [N_DIRECTED] = '{
		0, 1, 2, 3, 4, 5, 99, 100, 101, 199, 200, 1000, 4096,
		5461, 8191, 8192, 8193, 10922, 16383
	};

	localparam int N_WORDS = N_DIRECTED + N_RANDOM;
	localparam int LIMIT   = N_WORDS * SLOW_ITEM + LONG_HOLD + 1000;

	typedef struct {
		logic [X_W-1:0] x;
		logic [S_W-1:0] s;
		logic [H_W-1:0] h;
		logic [L_W-1:0] l;
		logic [L_W-1:0] l_prime;
	} raptor_params_t;

	class param_scoreboard;
		raptor_params_t expected_q[$];
		int failures = 0;

		function int least_prime_from(int n);
			int m;
			bit composite;
			m = n - 1;
			do begin
				m++;
				composite = (m < 2);
				for (int d = 2; d * d <= m && !composite; d++)
					composite = (m % d == 0);
			end while (composite);
			return m;
		endfunction

		function raptor_params_t derive_params(logic [K_W-1:0] k_in);
			int k, x, s, h, l, lp;
			longint cb, need;
			raptor_params_t p;
			k = k_in;
			if (k > DEFAULT_MAX_SOURCE_SYMBOLS)
				k = DEFAULT_MAX_SOURCE_SYMBOLS;
			x = 1;
			while (x * (x - 1) < 2 * k)
				x++;
			s = least_prime_from((k + 99) / 100 + x);
			need = k + s;
			h = 0;
			while (h < 63) begin
				// central binomial, built exactly
				cb = 1;
				for (int i = 0; i < (h + 1) / 2; i++)
					cb = cb * (h - i) / (i + 1);
				if (cb >= need)
					break;
				h++;
			end
			l = k + s + h;
			lp = least_prime_from(l);
			p.x       = x[X_W-1:0];
			p.s       = s[S_W-1:0];
			p.h       = h[H_W-1:0];
			p.l       = l[L_W-1:0];
			p.l_prime = lp[L_W-1:0];
			return p;
		endfunction

		function void note_block(logic [K_W-1:0] k);
			expected_q.push_back(derive_params(k));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string what, int exp_v, int act_v);
			failures++;
			if (failures <= 10)
				$display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, act_v);
		endfunction

		function void check_result(raptor_params_t got);
			raptor_params_t e;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] MISMATCH unexpected word: X=%0d S=%0d H=%0d L=%0d L'=%0d",
						$time, got.x, got.s, got.h, got.l, got.l_prime);
				return;
			end
			e = expected_q.pop_front();
			if (got.x !== e.x)             report("x_value", e.x, got.x);
			if (got.s !== e.s)             report("ldpc_symbols", e.s, got.s);
			if (got.h !== e.h)             report("half_symbols", e.h, got.h);
			if (got.l !== e.l)             report("intermediate_symbols", e.l, got.l);
			if (got.l_prime !== e.l_prime) report("prime_intermediate", e.l_prime, got.l_prime);
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	logic [K_W-1:0] source_symbols = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic [X_W-1:0] x_value;
	logic [S_W-1:0] ldpc_symbols;
	logic [H_W-1:0] half_symbols;
	logic [L_W-1:0] intermediate_symbols;
	logic [L_W-1:0] prime_intermediate;

	param_scoreboard sb = new();
	int words_sent = 0;
	int words_seen = 0;

	raptor_block_parameter_derivation_top i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.source_symbols       (source_symbols),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.x_value              (x_value),
		.ldpc_symbols         (ldpc_symbols),
		.half_symbols         (half_symbols),
		.intermediate_symbols (intermediate_symbols),
		.prime_intermediate   (prime_intermediate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// valid stays up across back-to-back words; only a gap lowers it
	task automatic send_block(input logic [K_W-1:0] k);
		in_valid <= 1'b1;
		source_symbols <= k;
		do @(posedge clk); while (!in_ready);
		sb.note_block(k);
		words_sent++;
		if (words_sent < N_WORDS - QUIET_WORDS && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	initial begin
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_block(DIRECTED[i][K_W-1:0]);
		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				send_block(K_W'($urandom_range(0, 16383)));
			else if (pick < 4)
				send_block(K_W'($urandom_range(0, 300)));
			else
				send_block(K_W'($urandom_range(1, 8192)));
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off so the input backs up
	initial begin
		int hold_cnt;
		bit quiet;
		raptor_params_t r;
		hold_cnt = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			quiet = (words_seen >= N_WORDS - QUIET_WORDS);
			if (out_valid && out_ready) begin
				r.x       = x_value;
				r.s       = ldpc_symbols;
				r.h       = half_symbols;
				r.l       = intermediate_symbols;
				r.l_prime = prime_intermediate;
				sb.check_result(r);
				words_seen++;
				if (words_seen == HOLD_AFTER)
					hold_cnt = LONG_HOLD;
				else if (!quiet && $urandom_range(0, 3) == 0)
					hold_cnt = $urandom_range(1, 19);
			end else if (hold_cnt == 0 && !quiet && $urandom_range(0, 63) == 0) begin
				hold_cnt = $urandom_range(1, 19);
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rbpd_pkg.sv
sv/rbpd_rem.sv
sv/raptor_block_parameter_derivation_top.sv
dv/raptor_block_parameter_derivation_tb.sv
